@@ rtl/sss_pkg.sv @@
// Shared types and constants for the streaming substring search block.
// No dependencies; imported by sss_cell and streaming_substring_search.
package sss_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  // Fixed field widths
  localparam int PAT_BYTES = 16;  // bytes held by the two pattern registers
  localparam int LEN_W     = 5;   // pattern_len register
  localparam int REG_W     = 64;  // widest configuration register
  localparam int IDX_W     = 2;   // configuration register index
  localparam int OUT_POS_W = 16;  // match_start field

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

  // Pattern bytes, byte 0 first
  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

endpackage

@@ rtl/sss_cell.sv @@
// One window cell: holds one recent text byte and checks it against the
// pattern byte that lines up with its slot. Depends on sss_pkg.
module sss_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [7:0]                    data_in,
  output logic [7:0]                    data_out,
  input  sss_pkg::pat_bytes_t           pattern,
  input  logic [sss_pkg::LEN_W-1:0]     len,
  input  logic                          hit_in,
  output logic                          hit_out
);
  import sss_pkg::*;

  localparam logic [LEN_W-1:0] CELL_IDX = IDX[LEN_W-1:0];

  logic             active;
  logic [LEN_W-1:0] sel;

  // Slot k holds the byte that pairs with pattern byte len-1-k
  assign active  = len > CELL_IDX;
  assign sel     = len - LEN_W'(1) - CELL_IDX;
  assign hit_out = hit_in & (~active | (data_in == pattern[sel[3:0]]));

  always_ff @(posedge clk) begin
    if (rst) begin
      data_out <= 8'd0;
    end else if (en) begin
      data_out <= data_in;
    end
  end

endmodule

@@ rtl/streaming_substring_search.sv @@
// Streaming substring search: window of cells compared against the pattern.
// Top level; depends on sss_pkg and sss_cell.
//
// Use:
//   Text enters on the s_ group, one byte per word, s_tlast on the final
//   byte of a text. Each text yields one result word on the m_ group when
//   its last byte is taken: found in bit 0, match_start in bits 16:1.
//   Pattern registers are written on the cfg port while no text is open.
//   Throughput: one byte per cycle while s_tready is high. Every byte is
//   compared against the pattern in the cycle it is taken, by a row of
//   MAX_PATTERN cells. The result word is valid the cycle after the last
//   byte is taken.
//   Stall: the result sits in an output register until taken. While it
//   waits and m_tready is low, s_tready is low; with m_tready high a new
//   byte is taken in the same cycle the result leaves.
//   Reset (rst, synchronous): clears the pattern registers, the window,
//   the byte count and the match record, and drops m_tvalid.
//   Positions saturate; a match starting past 2^POSITION_BITS-1 is dropped.
module streaming_substring_search #(
  parameter int MAX_PATTERN   = sss_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Config write port
  input  logic                      cfg_we,
  input  logic [sss_pkg::IDX_W-1:0] cfg_index,
  input  logic [sss_pkg::REG_W-1:0] cfg_data,
  // Text in
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] text_byte
  input  logic                      s_tlast,   // is_last
  // Result out
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata    // [0] found, [16:1] match_start, rest zero
);
  import sss_pkg::*;

  localparam int POS_W = POSITION_BITS + 1;
  // Count stops here, far enough past the last reportable start
  localparam logic [POS_W-1:0] POS_SAT =
    POS_W'((64'd1 << POSITION_BITS) + 64'(MAX_PATTERN) + 64'd1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  // Configuration registers
  logic [LEN_W-1:0] pattern_len;
  logic [REG_W-1:0] pattern_low;
  logic [REG_W-1:0] pattern_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      pattern_low  <= '0;
      pattern_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Effective length clamps to the number of cells
  logic [LEN_W-1:0] len_eff;
  assign len_eff = (pattern_len > LEN_MAX) ? LEN_MAX : pattern_len;

  pat_bytes_t pattern;
  for (genvar i = 0; i < PAT_BYTES; i++) begin : g_pat
    if (i < 8) begin : g_lo
      assign pattern[i] = pattern_low[8*i +: 8];
    end else begin : g_hi
      assign pattern[i] = pattern_high[8*(i-8) +: 8];
    end
  end

  // Handshakes
  logic in_acc;
  assign s_tready = ~m_tvalid | m_tready;
  assign in_acc   = s_tvalid & s_tready;

  // Cell row: bytes shift from cell k to k+1, hit flags AND along the row.
  // Each cell looks at the byte it is about to hold, i.e. the window after
  // this byte is shifted in.
  logic [MAX_PATTERN:0][7:0] chain_data;
  logic [MAX_PATTERN:0]      chain_hit;

  assign chain_data[0] = s_tdata;
  assign chain_hit[0]  = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    sss_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (in_acc),
      .data_in  (chain_data[k]),
      .data_out (chain_data[k+1]),
      .pattern  (pattern),
      .len      (len_eff),
      .hit_in   (chain_hit[k]),
      .hit_out  (chain_hit[k+1])
    );
  end

  // Stream state
  logic [POS_W-1:0]         byte_pos;
  logic                     seen_match;
  logic [POSITION_BITS-1:0] first_start;

  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] start_next;
  logic             match_now;

  assign pos_next   = (byte_pos < POS_SAT) ? byte_pos + POS_W'(1) : byte_pos;
  assign start_next = pos_next - POS_W'(len_eff);
  assign match_now  = (len_eff != '0) & ~seen_match & (pos_next >= POS_W'(len_eff))
                    & chain_hit[MAX_PATTERN] & (start_next <= POS_MAX);

  // Result fields for this byte if it closes the text
  logic                 res_found;
  logic [OUT_POS_W-1:0] res_start;

  always_comb begin
    res_found = 1'b0;
    res_start = '0;
    priority if (len_eff == '0) begin
      res_found = 1'b1;
    end else if (seen_match) begin
      res_found = 1'b1;
      res_start = OUT_POS_W'(first_start);
    end else if (match_now) begin
      res_found = 1'b1;
      res_start = OUT_POS_W'(start_next[POSITION_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      seen_match  <= 1'b0;
      first_start <= '0;
    end else if (in_acc) begin
      if (s_tlast) begin
        byte_pos    <= '0;
        seen_match  <= 1'b0;
        first_start <= '0;
      end else begin
        byte_pos <= pos_next;
        if (match_now) begin
          seen_match  <= 1'b1;
          first_start <= start_next[POSITION_BITS-1:0];
        end
      end
    end
  end

  // Output register
  logic                 out_found;
  logic [OUT_POS_W-1:0] out_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc & s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc & s_tlast) begin
      out_found <= res_found;
      out_start <= res_start;
    end
  end

  assign m_tdata = {7'd0, out_start, out_found};

endmodule

@@ rtl/sss_checker.sv @@
// Port-level checks for streaming_substring_search, bound to the top level.
// Depends on nothing but the top level's ports.
module sss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input is open whenever the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output register");

  // Last byte taken gives a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no result after last byte");

  // A new result only follows a last byte
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without last byte");

  // No match means zero offset
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
    else $error("nonzero offset without match");

endmodule

bind streaming_substring_search sss_checker u_sss_checker (.*);
